FILE: rtl/core/sfd_pkg.sv
// Shared types for the signed fractional divider.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package sfd_pkg;

    // Per-word control flags carried alongside the datapath through the cell row.
    typedef struct packed {
        logic negate;      // operand signs differ
        logic div_zero;    // divisor was zero
        logic force_zero;  // divisor was the most negative value
    } t_flags;

endpackage

`default_nettype wire

FILE: rtl/core/signed_fractional_divide.sv
// Top level of the signed Q(W-1) fractional divider: front stage, a row of
// 2W-1 division cells and an output stage. Depends on sfd_pkg, sfd_front,
// sfd_cell and sfd_back.
//
//  channel | dir | tdata (low bit up)                   | tuser
//  --------+-----+--------------------------------------+---------------
//  s       | in  | numerator[W-1:0], denominator[W-1:0] | -
//  m       | out | ratio[W-1:0]                         | divide_by_zero
//
// One word accepted per cycle while s_tready is high; each word passes through
// one front stage, one cell per dividend bit (the W numerator magnitude bits
// from the top down, then W-1 zero bits), and one output stage.
// Reset clears only the valid bits of the stages.
// Each stage holds its word until the next stage has room, so a stall on the
// m side fills the row stage by stage before s stops accepting.
`default_nettype none

module signed_fractional_divide #(
    parameter int WORD_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    // numerator, denominator
    input  wire logic [((2*WORD_BITS+7)/8)*8-1:0]      i_s_tdata,
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,
    // ratio
    output logic [((WORD_BITS+7)/8)*8-1:0]             o_m_tdata,
    // divide_by_zero
    output logic                                       o_m_tuser
);

    localparam int OUT_BITS = ((WORD_BITS+7)/8)*8;
    localparam int NCELLS   = 2*WORD_BITS-1;

    logic                 c_valid [NCELLS+1];
    logic                 c_ready [NCELLS+2];
    logic [WORD_BITS-2:0] c_rem   [NCELLS+1];
    logic [WORD_BITS-1:0] c_dvd   [NCELLS+1];
    logic [WORD_BITS-1:0] c_quo   [NCELLS+1];
    logic [WORD_BITS-2:0] c_div   [NCELLS+1];
    sfd_pkg::t_flags      c_flags [NCELLS+1];
    logic [WORD_BITS-1:0] ratio;

    assign c_rem[0] = '0;
    assign c_quo[0] = '0;

    sfd_front #(.WORD_BITS(WORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_num   (i_s_tdata[WORD_BITS-1:0]),
        .i_den   (i_s_tdata[2*WORD_BITS-1:WORD_BITS]),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[1]),
        .o_dvd   (c_dvd[0]),
        .o_div   (c_div[0]),
        .o_flags (c_flags[0])
    );

    for (genvar k = 1; k <= NCELLS; k++) begin : g_cell
        sfd_cell #(.WORD_BITS(WORD_BITS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k-1]),
            .o_ready (c_ready[k]),
            .i_rem   (c_rem[k-1]),
            .i_dvd   (c_dvd[k-1]),
            .i_quo   (c_quo[k-1]),
            .i_div   (c_div[k-1]),
            .i_flags (c_flags[k-1]),
            .o_valid (c_valid[k]),
            .i_ready (c_ready[k+1]),
            .o_rem   (c_rem[k]),
            .o_dvd   (c_dvd[k]),
            .o_quo   (c_quo[k]),
            .o_div   (c_div[k]),
            .o_flags (c_flags[k])
        );
    end

    // final remainder and leftover dividend bits are not needed
    sfd_back #(.WORD_BITS(WORD_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (c_valid[NCELLS]),
        .o_ready    (c_ready[NCELLS+1]),
        .i_quo      (c_quo[NCELLS]),
        .i_flags    (c_flags[NCELLS]),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_ratio    (ratio),
        .o_div_zero (o_m_tuser)
    );

    assign o_m_tdata = OUT_BITS'(ratio);

    // zero divisor always yields a zero ratio
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> ratio == '0)
        else $error("divide_by_zero word with nonzero ratio");

    // input side stalls only when the front stage is full and blocked
    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> c_valid[0] && !c_ready[1])
        else $error("input stalled with room in front stage");

    // a new output word can only come from a full last cell
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(c_valid[NCELLS]))
        else $error("output valid without a word in the last cell");

    // a word in the last cell moves on whenever the output stage is free
    a_last_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_valid[NCELLS] && !o_m_tvalid |=> o_m_tvalid)
        else $error("last cell word did not enter free output stage");

endmodule

`default_nettype wire

FILE: rtl/core/sfd_front.sv
// Input stage of the divider: sign split, magnitudes and special-case flags.
// Depends on sfd_pkg.
`default_nettype none

module sfd_front #(
    parameter int WORD_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [WORD_BITS-1:0] i_num,
    input  wire logic [WORD_BITS-1:0] i_den,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [WORD_BITS-1:0]      o_dvd,
    output logic [WORD_BITS-2:0]      o_div,
    output sfd_pkg::t_flags           o_flags
);

    logic                 r_valid;
    logic [WORD_BITS-1:0] r_dvd;
    logic [WORD_BITS-2:0] r_div;
    sfd_pkg::t_flags      r_flags;

    logic [WORD_BITS-1:0] n_dvd;
    logic [WORD_BITS-1:0] n_den_mag;
    sfd_pkg::t_flags      n_flags;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // most negative numerator maps to 2^(W-1), which still fits unsigned
        n_dvd     = i_num[WORD_BITS-1] ? (~i_num + 1'b1) : i_num;
        n_den_mag = i_den[WORD_BITS-1] ? (~i_den + 1'b1) : i_den;
        n_flags.negate     = i_num[WORD_BITS-1] ^ i_den[WORD_BITS-1];
        n_flags.div_zero   = (i_den == '0);
        n_flags.force_zero = (i_den == {1'b1, {(WORD_BITS-1){1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dvd   <= n_dvd;
            r_div   <= n_den_mag[WORD_BITS-2:0];
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_dvd   = r_dvd;
    assign o_div   = r_div;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

FILE: rtl/core/sfd_cell.sv
// One restoring-division cell: brings in one dividend bit, does a trial
// subtract and emits one quotient bit. Depends on sfd_pkg.
`default_nettype none

module sfd_cell #(
    parameter int WORD_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [WORD_BITS-2:0] i_rem,
    input  wire logic [WORD_BITS-1:0] i_dvd,
    input  wire logic [WORD_BITS-1:0] i_quo,
    input  wire logic [WORD_BITS-2:0] i_div,
    input  wire sfd_pkg::t_flags      i_flags,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [WORD_BITS-2:0]      o_rem,
    output logic [WORD_BITS-1:0]      o_dvd,
    output logic [WORD_BITS-1:0]      o_quo,
    output logic [WORD_BITS-2:0]      o_div,
    output sfd_pkg::t_flags           o_flags
);

    logic                 r_valid;
    logic [WORD_BITS-2:0] r_rem;
    logic [WORD_BITS-1:0] r_dvd;
    logic [WORD_BITS-1:0] r_quo;
    logic [WORD_BITS-2:0] r_div;
    sfd_pkg::t_flags      r_flags;

    logic [WORD_BITS-1:0] trial;
    logic [WORD_BITS-1:0] div_ext;
    logic [WORD_BITS-1:0] diff;
    logic                 ge;
    logic [WORD_BITS-2:0] n_rem;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        trial   = {i_rem, i_dvd[WORD_BITS-1]};
        div_ext = {1'b0, i_div};
        diff    = trial - div_ext;
        ge      = (trial >= div_ext);
        // remainder stays below the divisor, so it fits in W-1 bits
        n_rem   = ge ? diff[WORD_BITS-2:0] : trial[WORD_BITS-2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem   <= n_rem;
            r_dvd   <= {i_dvd[WORD_BITS-2:0], 1'b0};
            r_quo   <= {i_quo[WORD_BITS-2:0], ge};
            r_div   <= i_div;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_dvd   = r_dvd;
    assign o_quo   = r_quo;
    assign o_div   = r_div;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

FILE: rtl/core/sfd_back.sv
// Output stage: applies the sign and special cases, holds the result word.
// Depends on sfd_pkg.
`default_nettype none

module sfd_back #(
    parameter int WORD_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [WORD_BITS-1:0] i_quo,
    input  wire sfd_pkg::t_flags      i_flags,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [WORD_BITS-1:0]      o_ratio,
    output logic                      o_div_zero
);

    logic                 r_valid;
    logic [WORD_BITS-1:0] r_ratio;
    logic                 r_div_zero;
    logic [WORD_BITS-1:0] n_ratio;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        if (i_flags.div_zero || i_flags.force_zero) begin
            n_ratio = '0;
        end else if (i_flags.negate) begin
            n_ratio = ~i_quo + 1'b1;
        end else begin
            n_ratio = i_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ratio    <= n_ratio;
            r_div_zero <= i_flags.div_zero;
        end
    end

    assign o_valid    = r_valid;
    assign o_ratio    = r_ratio;
    assign o_div_zero = r_div_zero;

endmodule

`default_nettype wire
